// ===== rtl/core/icc_pkg.sv =====
// ----------------------------------------------------------------------------
// icc_pkg
// Types, register indexes and constants for the incubator climate and
// turner control core.
// ----------------------------------------------------------------------------
`default_nettype none

package icc_pkg;

	// defaults for the top-level parameters
	localparam int unsigned PULSE_MS_DEF             = 15000;
	localparam int unsigned DEFAULT_TURN_MINUTES_DEF = 120;

	localparam logic [31:0] MS_PER_MINUTE = 32'd60000;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_AUTO_MODE          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMPERATURE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HUMIDITY    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TURN_INTERVAL      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_OUTPUTS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_TIME         = 3'd5;

	// register reset values
	localparam logic [9:0] TARGET_TEMPERATURE_RST = 10'd375;
	localparam logic [9:0] TARGET_HUMIDITY_RST    = 10'd550;

	// manual_outputs bit positions
	localparam int MAN_HEATER = 0;
	localparam int MAN_BULB2  = 1;
	localparam int MAN_FAN    = 2;
	localparam int MAN_TURNER = 3;

	// status codes
	localparam logic [1:0] STAT_NONE = 2'd0;
	localparam logic [1:0] STAT_LOW  = 2'd1;
	localparam logic [1:0] STAT_OK   = 2'd2;
	localparam logic [1:0] STAT_HIGH = 2'd3;

	// bands, tenths of a degree / tenths of a percent
	localparam logic signed [12:0] HEAT_BAND  = 13'sd3;
	localparam logic signed [12:0] TEMP_BAND  = 13'sd5;
	localparam logic signed [12:0] HUMID_BAND = 13'sd50;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic               reading_present;
		logic               reading_valid;
		logic signed [11:0] temperature;
		logic [9:0]         humidity;
		logic               turn_request;
	} tick_t;

	typedef struct packed {
		logic        heater_on;
		logic        bulb2_on;
		logic        fan_on;
		logic        turner_on;
		logic        turn_started;
		logic [31:0] next_turn_ms;
		logic [1:0]  temp_status;
		logic [1:0]  humidity_status;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/icc_if.sv =====
// ----------------------------------------------------------------------------
// icc_tick_if / icc_result_if
// Valid/ready channels for tick words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface icc_tick_if;
	logic           valid;
	logic           ready;
	icc_pkg::tick_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface icc_result_if;
	logic             valid;
	logic             ready;
	icc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/incubator_climate_and_turner_control_core.sv =====
// ----------------------------------------------------------------------------
// incubator_climate_and_turner_control_core
// One tick word per cycle: latches readings, runs the turner pulse and the
// turn schedule, regulates heater, bulb2 and fan, reports status.
// ----------------------------------------------------------------------------
// An accepted tick word passes the input register, then the result register.
// Throughput: one tick per cycle; the only limit is the result port
// back-pressure, with one input register ahead.
// Reset (arst_n low): drives off, no pulse, no reading held, registers at
// their defaults (auto mode on, 37.5 C, 55.0 %, default turn interval).
`default_nettype none

module incubator_climate_and_turner_control_core #(
	parameter int unsigned PULSE_MS             = icc_pkg::PULSE_MS_DEF,
	parameter int unsigned DEFAULT_TURN_MINUTES = icc_pkg::DEFAULT_TURN_MINUTES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	icc_tick_if.sink                             tick,
	icc_result_if.source                         result,
	input  wire logic                            wr_en,
	input  wire logic [icc_pkg::CFG_IDX_W-1:0]   wr_index,
	input  wire logic [icc_pkg::CFG_DATA_W-1:0]  wr_data
);

	localparam logic [31:0] PULSE_LEN  = 32'(PULSE_MS);
	localparam logic [31:0] DEFAULT_IV = 32'(DEFAULT_TURN_MINUTES * 60000);

	// configuration
	logic        auto_mode_q;
	logic [9:0]  target_temp_q;
	logic [9:0]  target_hum_q;
	logic [31:0] interval_ms_q;
	logic [3:0]  manual_q;
	logic [31:0] start_time_q;

	// control state
	logic        heater_q, bulb2_q, fan_q, turner_q;
	logic        pulse_active_q;
	logic [31:0] pulse_end_q;
	logic [31:0] last_turn_q;
	logic        turned_once_q;
	logic        held_valid_q;
	logic [11:0] held_temp_q;
	logic [9:0]  held_hum_q;

	// pipeline
	logic             valid_s1;
	icc_pkg::tick_t   tick_s1;
	logic             out_valid_q;
	icc_pkg::result_t out_q;

	logic advance, step;

	assign advance      = !out_valid_q || result.ready;
	assign tick.ready   = !valid_s1 || advance;
	assign step         = valid_s1 && advance;
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	// ---------------- configuration decode ----------------
	logic        cfg_hit;
	logic        auto_next;
	logic [3:0]  manual_next;
	logic [10:0] wr_minutes;
	logic [31:0] wr_interval;

	assign wr_minutes  = wr_data[10:0];
	assign wr_interval = (wr_minutes == 11'd0) ? DEFAULT_IV
	                                           : {21'd0, wr_minutes} * icc_pkg::MS_PER_MINUTE;

	always_comb begin
		cfg_hit     = 1'b1;
		auto_next   = auto_mode_q;
		manual_next = manual_q;
		unique case (wr_index)
			icc_pkg::CFG_AUTO_MODE:          auto_next = wr_data[0];
			icc_pkg::CFG_TARGET_TEMPERATURE: cfg_hit = 1'b1;
			icc_pkg::CFG_TARGET_HUMIDITY:    cfg_hit = 1'b1;
			icc_pkg::CFG_TURN_INTERVAL:      cfg_hit = 1'b1;
			icc_pkg::CFG_MANUAL_OUTPUTS:     manual_next = wr_data[3:0];
			icc_pkg::CFG_START_TIME:         cfg_hit = 1'b1;
			default:                         cfg_hit = 1'b0;
		endcase
	end

	logic cfg_load_manual;
	assign cfg_load_manual = wr_en && cfg_hit && !auto_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_mode_q   <= 1'b1;
			target_temp_q <= icc_pkg::TARGET_TEMPERATURE_RST;
			target_hum_q  <= icc_pkg::TARGET_HUMIDITY_RST;
			interval_ms_q <= DEFAULT_IV;
			manual_q      <= 4'd0;
			start_time_q  <= 32'd0;
		end else if (wr_en) begin
			unique case (wr_index)
				icc_pkg::CFG_AUTO_MODE:          auto_mode_q   <= wr_data[0];
				icc_pkg::CFG_TARGET_TEMPERATURE: target_temp_q <= wr_data[9:0];
				icc_pkg::CFG_TARGET_HUMIDITY:    target_hum_q  <= wr_data[9:0];
				icc_pkg::CFG_TURN_INTERVAL:      interval_ms_q <= wr_interval;
				icc_pkg::CFG_MANUAL_OUTPUTS:     manual_q      <= wr_data[3:0];
				icc_pkg::CFG_START_TIME:         start_time_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// ---------------- tick datapath ----------------
	logic        req;
	logic [31:0] now;
	logic        hv;
	logic [11:0] ht;
	logic [9:0]  hh;

	assign now = tick_s1.now_ms;
	assign req = tick_s1.turn_request;
	assign hv  = tick_s1.reading_present ? tick_s1.reading_valid : held_valid_q;
	assign ht  = tick_s1.reading_present ? tick_s1.temperature   : held_temp_q;
	assign hh  = tick_s1.reading_present ? tick_s1.humidity      : held_hum_q;

	logic signed [12:0] t, tt, h, th;
	assign t  = {ht[11], ht};
	assign tt = {3'd0, target_temp_q};
	assign h  = {3'd0, hh};
	assign th = {3'd0, target_hum_q};

	logic heat_low, heat_high, temp_low, temp_high, hum_low, hum_high;
	assign heat_low  = t < tt - icc_pkg::HEAT_BAND;
	assign heat_high = t > tt + icc_pkg::HEAT_BAND;
	assign temp_low  = t < tt - icc_pkg::TEMP_BAND;
	assign temp_high = t > tt + icc_pkg::TEMP_BAND;
	assign hum_low   = h < th - icc_pkg::HUMID_BAND;
	assign hum_high  = h > th + icc_pkg::HUMID_BAND;

	// schedule: elapsed time since the last turn, or since start_time
	logic [31:0] base, elapsed, pulse_left;
	logic        due, still_on, pulse_ends, sched, turn;

	assign base       = turned_once_q ? last_turn_q : start_time_q;
	assign elapsed    = now - base;
	assign due        = elapsed >= interval_ms_q;
	assign pulse_left = now - pulse_end_q;
	// a fresh request restarts the pulse, so only an old pulse can end here
	assign still_on   = pulse_active_q && pulse_left[31];
	assign pulse_ends = pulse_active_q && !pulse_left[31] && !req;
	assign sched      = auto_mode_q && !req && !still_on && due;
	assign turn       = req || sched;

	logic        heater_n, bulb2_n, fan_n, turner_n;
	logic [31:0] next_n;
	logic [1:0]  ts_n, hs_n;

	always_comb begin
		heater_n = heater_q;
		bulb2_n  = bulb2_q;
		fan_n    = fan_q;
		if (auto_mode_q) begin
			if (!hv) begin
				heater_n = 1'b0;
				bulb2_n  = 1'b0;
				fan_n    = 1'b0;
			end else begin
				if (heat_low) begin
					heater_n = 1'b1;
					bulb2_n  = 1'b1;
				end else if (heat_high) begin
					heater_n = 1'b0;
					bulb2_n  = 1'b0;
				end
				fan_n = temp_high || hum_high;
			end
		end

		if (turn)
			turner_n = 1'b1;
		else if (pulse_ends)
			turner_n = auto_mode_q ? 1'b0 : manual_q[icc_pkg::MAN_TURNER];
		else
			turner_n = turner_q;

		if (turn)
			next_n = interval_ms_q;
		else if (due)
			next_n = 32'd0;
		else
			next_n = interval_ms_q - elapsed;

		if (!hv)            ts_n = icc_pkg::STAT_NONE;
		else if (temp_low)  ts_n = icc_pkg::STAT_LOW;
		else if (temp_high) ts_n = icc_pkg::STAT_HIGH;
		else                ts_n = icc_pkg::STAT_OK;

		if (!hv)           hs_n = icc_pkg::STAT_NONE;
		else if (hum_low)  hs_n = icc_pkg::STAT_LOW;
		else if (hum_high) hs_n = icc_pkg::STAT_HIGH;
		else               hs_n = icc_pkg::STAT_OK;
	end

	// ---------------- state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heater_q       <= 1'b0;
			bulb2_q        <= 1'b0;
			fan_q          <= 1'b0;
			turner_q       <= 1'b0;
			pulse_active_q <= 1'b0;
			pulse_end_q    <= 32'd0;
			last_turn_q    <= 32'd0;
			turned_once_q  <= 1'b0;
			held_valid_q   <= 1'b0;
			held_temp_q    <= 12'd0;
			held_hum_q     <= 10'd0;
		end else if (cfg_load_manual) begin
			heater_q <= manual_next[icc_pkg::MAN_HEATER];
			bulb2_q  <= manual_next[icc_pkg::MAN_BULB2];
			fan_q    <= manual_next[icc_pkg::MAN_FAN];
			turner_q <= manual_next[icc_pkg::MAN_TURNER];
		end else if (step) begin
			heater_q       <= heater_n;
			bulb2_q        <= bulb2_n;
			fan_q          <= fan_n;
			turner_q       <= turner_n;
			pulse_active_q <= turn || still_on;
			held_valid_q   <= hv;
			held_temp_q    <= ht;
			held_hum_q     <= hh;
			if (turn) begin
				pulse_end_q   <= now + PULSE_LEN;
				last_turn_q   <= now;
				turned_once_q <= 1'b1;
			end
		end
	end

	// ---------------- handshake ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (tick.ready)
				valid_s1 <= tick.valid;
			if (advance)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid)
			tick_s1 <= tick.data;
		if (step) begin
			out_q.heater_on       <= heater_n;
			out_q.bulb2_on        <= bulb2_n;
			out_q.fan_on          <= fan_n;
			out_q.turner_on       <= turner_n;
			out_q.turn_started    <= turn;
			out_q.next_turn_ms    <= next_n;
			out_q.temp_status     <= ts_n;
			out_q.humidity_status <= hs_n;
		end
	end

endmodule

`default_nettype wire
